// File: rtl/hdlc_pkg.sv
package hdlc_pkg;

    // Request kinds
    localparam logic [2:0] KIND_TX_WRITE   = 3'd0;
    localparam logic [2:0] KIND_TX_TICK    = 3'd1;
    localparam logic [2:0] KIND_RX_TICK    = 3'd2;
    localparam logic [2:0] KIND_RD_DATA    = 3'd3;
    localparam logic [2:0] KIND_RD_STATUS  = 3'd4;

    // Configuration register indexes
    localparam int          CFG_IDX_W       = 1;
    localparam logic        REG_TX_ENABLE   = 1'b0;
    localparam logic        REG_RX_ENABLE   = 1'b1;

    // Line patterns and limits
    localparam logic [7:0]  FLAG_PATTERN    = 8'h7E;
    localparam logic [7:0]  GO_AHEAD        = 8'h7F;
    localparam logic [2:0]  STUFF_LIMIT     = 3'd5;
    localparam logic [3:0]  TX_BYTE_BITS    = 4'd8;
    localparam int          RX_CNT_W        = 4;
    localparam int          CHAR_BITS_DEF   = 8;

    // Receive status bit positions
    localparam int          ST_EOM          = 0;
    localparam int          ST_ABORT        = 1;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       rx_bit;
    } in_t;

    typedef struct packed {
        logic       tx_serial_out;
        logic       tx_buffer_empty;
        logic       tx_active;
        logic       rx_data_available;
        logic       rx_status_available;
        logic       flag_found;
        logic       rx_active;
        logic [7:0] read_data;
    } out_t;

    // Transmitter view after a request
    typedef struct packed {
        logic line;
        logic hold_empty;
    } tx_stat_t;

    // Receiver view after a request
    typedef struct packed {
        logic data_avail;
        logic status_avail;
        logic flag_found;
        logic active;
    } rx_stat_t;

endpackage

// File: rtl/hdlc_tx.sv
module hdlc_tx (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  hdlc_pkg::in_t     item,
    input  logic              tx_enable,
    output hdlc_pkg::tx_stat_t stat_next
);

    logic [7:0] hold_reg,     hold_next;
    logic       hempty_reg,   hempty_next;
    logic [7:0] shift_reg,    shift_next;
    logic [3:0] bleft_reg,    bleft_next;
    logic [2:0] ones_reg,     ones_next;
    logic       stuff_reg,    stuff_next;
    logic       line_reg,     line_next;

    logic [7:0] sh0;
    logic [7:0] hold0;
    logic [3:0] bl0;
    logic [2:0] or0;
    logic [2:0] run;
    logic       st0;
    logic       he0;
    logic       load;
    logic       txb;

    // Next-state logic for one request
    always_comb
    begin
        hold_next   = hold_reg;
        hempty_next = hempty_reg;
        shift_next  = shift_reg;
        bleft_next  = bleft_reg;
        ones_next   = ones_reg;
        stuff_next  = stuff_reg;
        line_next   = line_reg;

        load  = (bleft_reg == 4'd0) && !hempty_reg;
        sh0   = load ? hold_reg : shift_reg;
        hold0 = load ? 8'd0 : hold_reg;
        bl0   = load ? hdlc_pkg::TX_BYTE_BITS : bleft_reg;
        or0   = load ? 3'd0 : ones_reg;
        st0   = load ? 1'b1 : stuff_reg;
        he0   = load ? 1'b1 : hempty_reg;
        txb   = sh0[0];
        run   = st0 ? (txb ? 3'(or0 + 3'd1) : 3'd0) : or0;

        if (step && item.kind == hdlc_pkg::KIND_TX_WRITE)
        begin
            hold_next   = item.data_byte;
            hempty_next = 1'b0;
        end
        else if (step && item.kind == hdlc_pkg::KIND_TX_TICK && tx_enable)
        begin
            hold_next   = hold0;
            hempty_next = he0;
            shift_next  = sh0;
            bleft_next  = bl0;
            ones_next   = or0;
            stuff_next  = st0;
            if (bl0 == 4'd0)
            begin
                // nothing to send: idle mark
                line_next = 1'b1;
            end
            else if (or0 == hdlc_pkg::STUFF_LIMIT)
            begin
                // stuffed zero, pending bit stays put
                ones_next = 3'd0;
                line_next = 1'b0;
            end
            else
            begin
                ones_next  = run;
                line_next  = txb;
                shift_next = {1'b0, sh0[7:1]};
                bleft_next = bl0 - 4'd1;
                if (bl0 == 4'd1)
                begin
                    shift_next = 8'd0;
                    if (!st0)
                    begin
                        hempty_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg   <= 8'd0;
            hempty_reg <= 1'b1;
            shift_reg  <= 8'd0;
            bleft_reg  <= 4'd0;
            ones_reg   <= 3'd0;
            stuff_reg  <= 1'b0;
            line_reg   <= 1'b1;
        end
        else
        begin
            hold_reg   <= hold_next;
            hempty_reg <= hempty_next;
            shift_reg  <= shift_next;
            bleft_reg  <= bleft_next;
            ones_reg   <= ones_next;
            stuff_reg  <= stuff_next;
            line_reg   <= line_next;
        end
    end

    assign stat_next.line       = line_next;
    assign stat_next.hold_empty = hempty_next;

    // Ones run never passes the stuffing limit
    a_ones_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ones_reg <= hdlc_pkg::STUFF_LIMIT)
        else $error("ones run beyond stuffing limit");

    // A byte in flight was loaded, so stuffing is on
    a_busy_stuff: assert property (@(posedge clk) disable iff (!rst_n)
        (bleft_reg != 4'd0) |-> (stuff_reg && bleft_reg <= hdlc_pkg::TX_BYTE_BITS))
        else $error("byte in flight without stuffing");

endmodule

// File: rtl/hdlc_rx.sv
module hdlc_rx #(
    parameter int CHAR_BITS = hdlc_pkg::CHAR_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  hdlc_pkg::in_t      item,
    input  logic               rx_enable,
    input  logic               clear,
    output hdlc_pkg::rx_stat_t stat_next,
    output logic [7:0]         char_data,
    output logic [1:0]         status_data
);

    localparam logic [hdlc_pkg::RX_CNT_W-1:0] CHAR_CNT = hdlc_pkg::RX_CNT_W'(CHAR_BITS);
    localparam logic [hdlc_pkg::RX_CNT_W-1:0] CNT_ONE  = hdlc_pkg::RX_CNT_W'(1);

    logic [7:0]                  win_reg,    win_next;
    logic [hdlc_pkg::RX_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                        flag_reg,   flag_next;
    logic [CHAR_BITS-1:0]        char_reg,   char_next;
    logic                        davail_reg, davail_next;
    logic                        savail_reg, savail_next;
    logic                        active_reg, active_next;
    logic [1:0]                  stbits_reg, stbits_next;

    logic [7:0]                  win_sh;
    logic [hdlc_pkg::RX_CNT_W-1:0] cnt_inc;
    logic [hdlc_pkg::RX_CNT_W-1:0] cnt_a;
    logic                        is_flag;
    logic                        is_ga;
    logic                        flag_a;

    // Next-state logic for one request
    always_comb
    begin
        win_next    = win_reg;
        cnt_next    = cnt_reg;
        flag_next   = flag_reg;
        char_next   = char_reg;
        davail_next = davail_reg;
        savail_next = savail_reg;
        active_next = active_reg;
        stbits_next = stbits_reg;

        win_sh  = {win_reg[6:0], item.rx_bit};
        cnt_inc = cnt_reg + CNT_ONE;
        is_flag = (win_sh == hdlc_pkg::FLAG_PATTERN);
        is_ga   = (win_sh == hdlc_pkg::GO_AHEAD);
        cnt_a   = (is_flag || is_ga) ? '0 : cnt_inc;
        flag_a  = flag_reg || is_flag;

        if (step && item.kind == hdlc_pkg::KIND_RX_TICK && rx_enable)
        begin
            win_next  = win_sh;
            cnt_next  = cnt_a;
            flag_next = flag_a;
            // end of message: flag closes a full character
            if (is_flag && cnt_inc >= CHAR_CNT)
            begin
                stbits_next[hdlc_pkg::ST_EOM] = 1'b1;
                savail_next = 1'b1;
            end
            if (is_ga)
            begin
                stbits_next[hdlc_pkg::ST_ABORT] = 1'b1;
                savail_next = 1'b1;
            end
            // character boundary
            if (cnt_a >= CHAR_CNT)
            begin
                if (flag_a)
                begin
                    char_next   = win_sh[CHAR_BITS-1:0];
                    davail_next = 1'b1;
                    active_next = 1'b1;
                end
                cnt_next = '0;
                win_next = 8'd0;
            end
        end
        else if (step && item.kind == hdlc_pkg::KIND_RD_DATA)
        begin
            davail_next = 1'b0;
        end
        else if (step && item.kind == hdlc_pkg::KIND_RD_STATUS)
        begin
            stbits_next = 2'd0;
            savail_next = 1'b0;
        end
        else if (clear)
        begin
            davail_next = 1'b0;
            savail_next = 1'b0;
            active_next = 1'b0;
            stbits_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= 8'd0;
            cnt_reg    <= '0;
            flag_reg   <= 1'b0;
            char_reg   <= '0;
            davail_reg <= 1'b0;
            savail_reg <= 1'b0;
            active_reg <= 1'b0;
            stbits_reg <= 2'd0;
        end
        else
        begin
            win_reg    <= win_next;
            cnt_reg    <= cnt_next;
            flag_reg   <= flag_next;
            char_reg   <= char_next;
            davail_reg <= davail_next;
            savail_reg <= savail_next;
            active_reg <= active_next;
            stbits_reg <= stbits_next;
        end
    end

    assign stat_next.data_avail   = davail_next;
    assign stat_next.status_avail = savail_next;
    assign stat_next.flag_found   = flag_next;
    assign stat_next.active       = active_next;
    assign char_data              = 8'(char_reg);
    assign status_data            = stbits_reg;

    // Bit count wraps at the character length
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CHAR_CNT)
        else $error("receive bit count past character length");

    // Any set status bit always has pending status behind it
    a_status_bits: assert property (@(posedge clk) disable iff (!rst_n)
        (stbits_reg != 2'd0) |-> savail_reg)
        else $error("status bits set without status available");

endmodule

// File: rtl/hdlc_bit_serial_engine_core.sv
// Channel  | Signals                          | Direction | Moves
// ---------+----------------------------------+-----------+-----------------------------
// in       | in_valid, in_ready, in_item      | input     | one request (kind, byte, bit)
// out      | out_valid, out_ready, out_item   | output    | one result per request
// cfg      | cfg_valid, cfg_ready, cfg_index, | input     | enable register write
//          | cfg_data                         |           |
//
// One request per cycle sustained while out_ready stays high; out_valid rises once a request
// has passed through the input register into the result register. The transmitter and receiver
// update as a request moves from the input register into the result register.
// A waiting result still lets one request into the input register; a second holds in_ready low.
// cfg_ready is always high; writes are registered, so a request advancing with the write sees the old setting.
// Reset: asynchronous, active low, no clearing pass.
module hdlc_bit_serial_engine_core #(
    parameter int CHAR_BITS = hdlc_pkg::CHAR_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  hdlc_pkg::in_t                  in_item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output hdlc_pkg::out_t                 out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hdlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           cfg_data
);

    logic               stage_valid_reg, stage_valid_next;
    hdlc_pkg::in_t      stage_item_reg;
    logic               out_valid_reg,   out_valid_next;
    hdlc_pkg::out_t     out_item_reg,    out_item_next;
    logic               tx_en_reg,       tx_en_next;
    logic               rx_en_reg,       rx_en_next;

    logic               advance;
    logic               cfg_fire;
    logic               rx_clear;
    hdlc_pkg::tx_stat_t tx_stat;
    hdlc_pkg::rx_stat_t rx_stat;
    logic [7:0]         char_data;
    logic [1:0]         status_data;

    // Handshake control
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign rx_clear  = cfg_fire && cfg_index == hdlc_pkg::REG_RX_ENABLE
                       && rx_en_reg && !cfg_data;

    // Enable registers
    always_comb
    begin
        tx_en_next = tx_en_reg;
        rx_en_next = rx_en_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                hdlc_pkg::REG_TX_ENABLE: tx_en_next = cfg_data;
                hdlc_pkg::REG_RX_ENABLE: rx_en_next = cfg_data;
                default: ;
            endcase
        end
    end

    hdlc_tx u_tx (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (stage_item_reg),
        .tx_enable (tx_en_reg),
        .stat_next (tx_stat)
    );

    hdlc_rx #(
        .CHAR_BITS (CHAR_BITS)
    ) u_rx (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (stage_item_reg),
        .rx_enable   (rx_en_reg),
        .clear       (rx_clear),
        .stat_next   (rx_stat),
        .char_data   (char_data),
        .status_data (status_data)
    );

    // Result assembly
    always_comb
    begin
        out_item_next                     = out_item_reg;
        out_valid_next                    = out_valid_reg && !out_ready;
        stage_valid_next                  = stage_valid_reg && !advance;
        if (in_valid && in_ready)
        begin
            stage_valid_next = 1'b1;
        end
        if (advance)
        begin
            out_valid_next                    = 1'b1;
            out_item_next.tx_serial_out       = tx_stat.line;
            out_item_next.tx_buffer_empty     = tx_stat.hold_empty;
            out_item_next.tx_active           = tx_en_reg;
            out_item_next.rx_data_available   = rx_stat.data_avail;
            out_item_next.rx_status_available = rx_stat.status_avail;
            out_item_next.flag_found          = rx_stat.flag_found;
            out_item_next.rx_active           = rx_stat.active;
            case (stage_item_reg.kind)
                hdlc_pkg::KIND_RD_DATA:   out_item_next.read_data = char_data;
                hdlc_pkg::KIND_RD_STATUS: out_item_next.read_data = {6'd0, status_data};
                default:                  out_item_next.read_data = 8'd0;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            tx_en_reg       <= 1'b0;
            rx_en_reg       <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
            tx_en_reg       <= tx_en_next;
            rx_en_reg       <= rx_en_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_item_reg <= in_item;
        end
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // A request leaving the input register always lands in the result register
    a_advance_lands: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed request produced no result");

    // A stalled result is neither dropped nor replaced
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_item_reg)))
        else $error("stalled result changed");

    // No request advances into a full, stalled result register
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !advance)
        else $error("result register overrun");

endmodule

// File: dv/tb_hdlc_bit_serial_engine_core.sv
module tb_hdlc_bit_serial_engine_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_W         = hdlc_pkg::CHAR_BITS_DEF;
    localparam int REPORT_LIMIT   = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_ITEMS    = 60;
    localparam int RANDOM_PHASES  = 8;

    // Kinds past the last decoded one are ignored by the engine
    localparam logic [2:0] KIND_SPARE_LAST = 3'd7;

    // Enable settings per random phase, {tx_enable, rx_enable}
    localparam logic [1:0] PHASE_ENABLES [0:7] =
        '{2'b11, 2'b10, 2'b11, 2'b01, 2'b00, 2'b11, 2'b10, 2'b11};

    // Directed step: either an enable write or one request with an optional fixed view
    typedef struct packed {
        logic           is_cfg;
        logic           cfg_reg;
        logic           cfg_val;
        hdlc_pkg::in_t  req;
        logic           pinned;
        hdlc_pkg::out_t want;
    } step_row_t;

    localparam hdlc_pkg::in_t  NO_REQUEST    = '0;
    localparam hdlc_pkg::out_t NO_VIEW       = '0;
    localparam hdlc_pkg::out_t VIEW_RESET    =
        '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
    localparam hdlc_pkg::out_t VIEW_TX_IDLE  =
        '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
    localparam hdlc_pkg::out_t VIEW_EOM_READ =
        '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h01};
    localparam hdlc_pkg::out_t VIEW_NO_CHAR  =
        '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00};

    localparam step_row_t DIRECTED_STEPS [0:27] = '{
        // fresh out of reset, disabled ticks and a spare kind leave everything alone
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RD_STATUS, 8'h00, 1'b0}, 1'b1, VIEW_RESET},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'hFF, 1'b1}, 1'b1, VIEW_RESET},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RX_TICK, 8'h00, 1'b1}, 1'b1, VIEW_RESET},
        '{1'b0, 1'b0, 1'b0, '{KIND_SPARE_LAST, 8'hFF, 1'b1}, 1'b1, VIEW_RESET},
        '{1'b1, hdlc_pkg::REG_TX_ENABLE, 1'b1, NO_REQUEST, 1'b0, NO_VIEW},
        // idle transmitter drives mark
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b1, VIEW_TX_IDLE},
        // held byte replaced, then all ones through the stuffer
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_WRITE, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_WRITE, 8'hFF, 1'b1}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_TX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b1, hdlc_pkg::REG_RX_ENABLE, 1'b1, NO_REQUEST, 1'b0, NO_VIEW},
        // first flag lands on a full bit count, so end of message is flagged
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RX_TICK, 8'h00, 1'b1}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RX_TICK, 8'h00, 1'b1}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RX_TICK, 8'h00, 1'b1}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RX_TICK, 8'h00, 1'b1}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RX_TICK, 8'h00, 1'b1}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RX_TICK, 8'h00, 1'b1}, 1'b0, NO_VIEW},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RX_TICK, 8'h00, 1'b0}, 1'b0, NO_VIEW},
        // status read clears it; data read returns the untouched character
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RD_STATUS, 8'hFF, 1'b1}, 1'b1, VIEW_EOM_READ},
        '{1'b0, 1'b0, 1'b0, '{hdlc_pkg::KIND_RD_DATA, 8'h00, 1'b0}, 1'b1, VIEW_NO_CHAR}
    };

    logic                           clk          = 1'b0;
    logic                           rst_n        = 1'b0;
    logic                           in_valid     = 1'b0;
    logic                           in_ready;
    hdlc_pkg::in_t                  in_item      = '0;
    logic                           out_valid;
    logic                           out_ready    = 1'b0;
    hdlc_pkg::out_t                 out_item;
    logic                           cfg_valid    = 1'b0;
    logic                           cfg_ready;
    logic [hdlc_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
    logic                           cfg_data     = 1'b0;

    // Side data travelling with each request: a fixed view for directed rows
    logic           drive_pinned = 1'b0;
    hdlc_pkg::out_t drive_want   = '0;

    hdlc_pkg::out_t expected_views [$];
    int   requests_sent  = 0;
    int   results_seen   = 0;
    int   fault_count    = 0;
    int   quiet_cycles   = 0;
    int   sink_wait      = 0;
    bit   source_eager   = 1'b0;
    bit   sink_eager     = 1'b0;

    // Engine shadow state
    logic       m_tx_on        = 1'b0;
    logic       m_rx_on        = 1'b0;
    logic [7:0] m_hold         = '0;
    logic       m_hold_empty   = 1'b1;
    logic [7:0] m_shift        = '0;
    logic [3:0] m_bits_left    = '0;
    logic [2:0] m_ones         = '0;
    logic       m_stuffing     = 1'b0;
    logic       m_line         = 1'b1;
    logic [7:0] m_window       = '0;
    logic [3:0] m_rx_count     = '0;
    logic       m_flag_seen    = 1'b0;
    logic [7:0] m_char         = '0;
    logic       m_data_avail   = 1'b0;
    logic       m_status_avail = 1'b0;
    logic       m_rx_active    = 1'b0;
    logic [1:0] m_status       = '0;

    hdlc_bit_serial_engine_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // Advance the shadow engine by one request and return the host view after it
    function automatic hdlc_pkg::out_t engine_step(input hdlc_pkg::in_t req);
        hdlc_pkg::out_t view;
        logic [7:0]     rd;
        logic           five;
        logic           bit_now;
        logic [2:0]     run;
        rd = '0;
        case (req.kind)
            hdlc_pkg::KIND_TX_WRITE:
            begin
                m_hold       = req.data_byte;
                m_hold_empty = 1'b0;
            end
            hdlc_pkg::KIND_TX_TICK:
            begin
                if (m_tx_on)
                begin
                    // reload once the shifter has drained
                    if (m_bits_left == 0 && !m_hold_empty)
                    begin
                        m_shift      = m_hold;
                        m_hold       = '0;
                        m_bits_left  = hdlc_pkg::TX_BYTE_BITS;
                        m_ones       = '0;
                        m_stuffing   = 1'b1;
                        m_hold_empty = 1'b1;
                    end
                    if (m_bits_left == 0)
                        m_line = 1'b1;
                    else
                    begin
                        five    = (m_ones == hdlc_pkg::STUFF_LIMIT);
                        bit_now = m_shift[0];
                        run     = m_ones;
                        if (m_stuffing)
                            run = bit_now ? run + 3'd1 : 3'd0;
                        if (five)
                        begin
                            // stuffed zero, pending bit holds for the next tick
                            m_ones = '0;
                            m_line = 1'b0;
                        end
                        else
                        begin
                            m_ones      = run;
                            m_line      = bit_now;
                            m_shift     = m_shift >> 1;
                            m_bits_left = m_bits_left - 4'd1;
                            if (m_bits_left == 0)
                            begin
                                m_shift = '0;
                                if (!m_stuffing)
                                    m_hold_empty = 1'b1;
                            end
                        end
                    end
                end
            end
            hdlc_pkg::KIND_RX_TICK:
            begin
                if (m_rx_on)
                begin
                    m_window   = {m_window[6:0], req.rx_bit};
                    m_rx_count = m_rx_count + 4'd1;
                    // pattern hunt
                    if (m_window == hdlc_pkg::FLAG_PATTERN)
                    begin
                        m_flag_seen = 1'b1;
                        if (m_rx_count >= CHAR_W)
                        begin
                            m_status[hdlc_pkg::ST_EOM] = 1'b1;
                            m_status_avail             = 1'b1;
                        end
                        m_rx_count = '0;
                    end
                    else if (m_window == hdlc_pkg::GO_AHEAD)
                    begin
                        m_status[hdlc_pkg::ST_ABORT] = 1'b1;
                        m_status_avail               = 1'b1;
                        m_rx_count                   = '0;
                    end
                    // character assembly, kept only after a flag
                    if (m_rx_count >= CHAR_W)
                    begin
                        if (m_flag_seen)
                        begin
                            m_char       = m_window & 8'((1 << CHAR_W) - 1);
                            m_data_avail = 1'b1;
                            m_rx_active  = 1'b1;
                        end
                        m_rx_count = '0;
                        m_window   = '0;
                    end
                end
            end
            hdlc_pkg::KIND_RD_DATA:
            begin
                rd           = m_char;
                m_data_avail = 1'b0;
            end
            hdlc_pkg::KIND_RD_STATUS:
            begin
                rd             = {6'd0, m_status};
                m_status       = '0;
                m_status_avail = 1'b0;
            end
            default: ;
        endcase
        view.tx_serial_out       = m_line;
        view.tx_buffer_empty     = m_hold_empty;
        view.tx_active           = m_tx_on;
        view.rx_data_available   = m_data_avail;
        view.rx_status_available = m_status_avail;
        view.flag_found          = m_flag_seen;
        view.rx_active           = m_rx_active;
        view.read_data           = rd;
        return view;
    endfunction

    function automatic hdlc_pkg::in_t request_of(input logic [2:0] k, input logic [7:0] d,
                                                 input logic b);
        hdlc_pkg::in_t req;
        req.kind      = k;
        req.data_byte = d;
        req.rx_bit    = b;
        return req;
    endfunction

    // Hand one request to the engine after a random gap
    task automatic send_request(input hdlc_pkg::in_t req, input logic pin,
                                input hdlc_pkg::out_t want);
        int gap;
        gap = source_eager ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        in_item      <= req;
        drive_pinned <= pin;
        drive_want   <= want;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        requests_sent++;
    endtask

    // Serialize a byte onto the receive line, MSB first into the window
    task automatic send_rx_byte(input logic [7:0] pattern);
        for (int i = 7; i >= 0; i--)
            send_request(request_of(hdlc_pkg::KIND_RX_TICK, 8'($urandom), pattern[i]),
                         1'b0, NO_VIEW);
    endtask

    // Leaves cfg_valid high; the caller lowers it after its last write
    task automatic write_register(input logic idx, input logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Stop sending, wait for every outstanding result, then let the engine settle
    task automatic settle_idle();
        in_valid <= 1'b0;
        while (results_seen != requests_sent) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_burst();
        int         pick;
        int         chars;
        logic [7:0] value;
        pick = $urandom_range(0, 9);
        if (pick < 4)
        begin
            // framed receive: flag, characters (sometimes an abort), usually a closing flag
            send_rx_byte(hdlc_pkg::FLAG_PATTERN);
            chars = $urandom_range(1, 3);
            repeat (chars)
            begin
                value = ($urandom_range(0, 9) == 0) ? hdlc_pkg::GO_AHEAD : 8'($urandom);
                send_rx_byte(value);
                if ($urandom_range(0, 1) == 1)
                    send_request(request_of(hdlc_pkg::KIND_RD_DATA, 8'($urandom),
                                            1'($urandom)), 1'b0, NO_VIEW);
            end
            if ($urandom_range(0, 3) != 0)
                send_rx_byte(hdlc_pkg::FLAG_PATTERN);
            send_request(request_of(hdlc_pkg::KIND_RD_STATUS, 8'($urandom), 1'($urandom)),
                         1'b0, NO_VIEW);
        end
        else if (pick < 7)
        begin
            // a byte through the transmitter with occasional further writes, biased toward long runs of ones
            case ($urandom_range(0, 2))
                0:       value = 8'hFF;
                1:       value = 8'($urandom | $urandom);
                default: value = 8'($urandom);
            endcase
            send_request(request_of(hdlc_pkg::KIND_TX_WRITE, value, 1'($urandom)),
                         1'b0, NO_VIEW);
            repeat ($urandom_range(6, 12))
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(request_of(hdlc_pkg::KIND_TX_WRITE, 8'($urandom),
                                            1'($urandom)), 1'b0, NO_VIEW);
                else
                    send_request(request_of(hdlc_pkg::KIND_TX_TICK, 8'($urandom),
                                            1'($urandom)), 1'b0, NO_VIEW);
            end
        end
        else if (pick == 7)
        begin
            value = 8'($urandom);
            send_request(request_of(value[0] ? hdlc_pkg::KIND_RD_DATA
                                             : hdlc_pkg::KIND_RD_STATUS, value,
                                    1'($urandom)), 1'b0, NO_VIEW);
        end
        else
        begin
            // noise over every kind, spare ones included
            send_request(request_of(3'($urandom_range(hdlc_pkg::KIND_TX_WRITE,
                                                      KIND_SPARE_LAST)),
                                    8'($urandom), 1'($urandom)), 1'b0, NO_VIEW);
        end
    endtask

    // Result sink: random stall after each taken result
    always @(posedge clk)
    begin : sink_pacing
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            sink_wait = sink_eager ? 0 : $urandom_range(0, 5);
            out_ready <= (sink_wait == 0);
        end
        else if (sink_wait > 0)
        begin
            sink_wait = sink_wait - 1;
            out_ready <= (sink_wait == 0);
        end
        else
            out_ready <= 1'b1;
    end

    // Prediction on accepted requests, checking on accepted results
    always @(posedge clk)
    begin : scoreboard
        hdlc_pkg::out_t predicted;
        hdlc_pkg::out_t oldest;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == hdlc_pkg::REG_TX_ENABLE)
                    m_tx_on = cfg_data;
                else
                begin
                    // dropping the receiver enable flushes its host flags
                    if (m_rx_on && !cfg_data)
                    begin
                        m_data_avail   = 1'b0;
                        m_status_avail = 1'b0;
                        m_rx_active    = 1'b0;
                        m_status       = '0;
                    end
                    m_rx_on = cfg_data;
                end
            end
            if (in_valid && in_ready)
            begin
                predicted = engine_step(in_item);
                expected_views.push_back(drive_pinned ? drive_want : predicted);
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_views.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $display("unexpected result %p", out_item);
                    fault_count++;
                end
                else
                begin
                    oldest = expected_views.pop_front();
                    if (out_item !== oldest)
                    begin
                        if (fault_count < REPORT_LIMIT)
                            $display("result %0d mismatch: expected %p got %p",
                                     results_seen, oldest, out_item);
                        fault_count++;
                    end
                end
            end
        end
    end

    // Watchdog on handshake activity
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        logic [1:0] enables;
        int         phase_end;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIRECTED_STEPS[i])
        begin
            if (DIRECTED_STEPS[i].is_cfg)
            begin
                settle_idle();
                write_register(DIRECTED_STEPS[i].cfg_reg, DIRECTED_STEPS[i].cfg_val);
                cfg_valid <= 1'b0;
            end
            else
                send_request(DIRECTED_STEPS[i].req, DIRECTED_STEPS[i].pinned,
                             DIRECTED_STEPS[i].want);
        end

        // random phases, each under its own enable setting and pacing
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle_idle();
            enables      = PHASE_ENABLES[phase];
            source_eager = ($urandom_range(0, 3) == 0);
            sink_eager   = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1) == 1)
            begin
                write_register(hdlc_pkg::REG_TX_ENABLE, enables[1]);
                write_register(hdlc_pkg::REG_RX_ENABLE, enables[0]);
            end
            else
            begin
                write_register(hdlc_pkg::REG_RX_ENABLE, enables[0]);
                write_register(hdlc_pkg::REG_TX_ENABLE, enables[1]);
            end
            cfg_valid <= 1'b0;
            phase_end = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_end)
                random_burst();
        end

        settle_idle();
        if (expected_views.size() != 0)
        begin
            if (fault_count < REPORT_LIMIT)
                $display("%0d expected results never arrived", expected_views.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
